FILE: hw/rtl/cfpr_pkg.sv
package cfpr_pkg;

   // payload buffer geometry
   localparam int BUF_DEPTH = 64;
   localparam int ADDR_W    = 6;
   localparam int CNT_W     = 7;

   // crc16, msb first, no reflection, no final xor
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_MSB  = 16'h8000;

   // result codes
   typedef enum logic [1:0] {
      KIND_GOOD     = 2'd0,
      KIND_CRC_ERR  = 2'd1,
      KIND_TOO_BIG  = 2'd2
   } kind_type;

   // configuration register indexes
   typedef enum logic {
      CSR_MAGIC_FIRST  = 1'b0,
      CSR_MAGIC_SECOND = 1'b1
   } csr_index_type;

   // one byte through the crc, eight shift steps
   function automatic logic [15:0] crc16_feed(input logic [15:0] crc_i, input logic [7:0] b_i);
      logic [15:0] c;
      c = crc_i ^ {b_i, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_MSB) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

FILE: hw/rtl/crc_framed_packet_receiver_unit.sv
// a crc error or an empty good frame is on rsp_ in the cycle after the closing beat; a
//   too-big error is registered from the length high byte; one rx beat per cycle while a
//   frame comes in and the result slot is free; a good frame's payload is replayed from
//   the payload memory (read, then send once the slot is free), during which req_ready is low
// reset (synchronous, active high): parser hunts for the first magic byte, crc = 0xFFFF,
//   magic bytes 0xAA / 0x55; the payload memory is not cleared
module crc_framed_packet_receiver_unit
   import cfpr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   // received byte stream
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_rx_byte,

   // frame results
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_kind,
   output logic [7:0]          rsp_frame_type,
   output logic [15:0]         rsp_payload_len,
   output logic                rsp_has_data,
   output logic [7:0]          rsp_data_byte,
   output logic [ADDR_W-1:0]   rsp_byte_index,
   output logic                rsp_last,

   // configuration writes
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [7:0]          csr_wdata
);

   // parser phases, then the two replay steps
   typedef enum logic [3:0] {
      PH_MAGIC0,
      PH_MAGIC1,
      PH_TYPE,
      PH_LENLO,
      PH_LENHI,
      PH_DATA,
      PH_CRCLO,
      PH_CRCHI,
      ST_READ,
      ST_SEND
   } state_type;

   state_type          st_ff,        st_in;
   logic [7:0]         magic0_ff,    magic0_in;
   logic [7:0]         magic1_ff,    magic1_in;
   logic [7:0]         ftype_ff,     ftype_in;
   logic [15:0]        flen_ff,      flen_in;
   logic [CNT_W-1:0]   cnt_ff,       cnt_in;
   logic [15:0]        crc_ff,       crc_in;
   logic [7:0]         crc_lo_ff,    crc_lo_in;
   logic [ADDR_W-1:0]  idx_ff,       idx_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   kind_type           kind_ff,      kind_in;
   logic [7:0]         mtype_ff,     mtype_in;
   logic [15:0]        plen_ff,      plen_in;
   logic               hasd_ff,      hasd_in;
   logic [7:0]         dbyte_ff,     dbyte_in;
   logic [ADDR_W-1:0]  bidx_ff,      bidx_in;
   logic               last_ff,      last_in;

   // payload memory, one write port (rx side) and one registered read port (replay side);
   // writes happen only while receiving and reads only while replaying, so they never meet
   logic [7:0]         pay_mem [BUF_DEPTH];
   logic [7:0]         rd_data_ff;
   logic               mem_we;
   logic               mem_rd;

   logic               slot_free;
   logic               rx_phase;
   logic               accept;
   logic [15:0]        len_new;
   logic [CNT_W-1:0]   cnt_plus;
   logic [15:0]        crc_rx;
   logic               replay_last;

   always_comb begin
      // output slot can take a new result this cycle
      slot_free   = !rsp_valid_ff || rsp_ready;
      rx_phase    = (st_ff inside {PH_MAGIC0, PH_MAGIC1, PH_TYPE, PH_LENLO,
                                   PH_LENHI, PH_DATA, PH_CRCLO, PH_CRCHI});
      req_ready   = rx_phase && slot_free;
      accept      = req_valid && req_ready;
      len_new     = {req_rx_byte, flen_ff[7:0]};
      cnt_plus    = cnt_ff + CNT_W'(1);
      crc_rx      = {req_rx_byte, crc_lo_ff};
      replay_last = ({1'b0, idx_ff} + CNT_W'(1)) == flen_ff[CNT_W-1:0];

      st_in        = st_ff;
      ftype_in     = ftype_ff;
      flen_in      = flen_ff;
      cnt_in       = cnt_ff;
      crc_in       = crc_ff;
      crc_lo_in    = crc_lo_ff;
      idx_in       = idx_ff;
      mem_we       = 1'b0;
      mem_rd       = 1'b0;

      // result beat leaves when taken
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      kind_in      = kind_ff;
      mtype_in     = mtype_ff;
      plen_in      = plen_ff;
      hasd_in      = hasd_ff;
      dbyte_in     = dbyte_ff;
      bidx_in      = bidx_ff;
      last_in      = last_ff;

      // configuration port
      magic0_in = magic0_ff;
      magic1_in = magic1_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_MAGIC_FIRST:  magic0_in = csr_wdata;
            CSR_MAGIC_SECOND: magic1_in = csr_wdata;
            default:          magic0_in = magic0_ff;
         endcase
      end

      case (st_ff)
         PH_MAGIC0: begin
            if (accept && req_rx_byte == magic0_ff) begin
               st_in = PH_MAGIC1;
            end
         end
         PH_MAGIC1: begin
            // a wrong second byte is not retried as a first byte
            if (accept) begin
               if (req_rx_byte == magic1_ff) begin
                  st_in = PH_TYPE;
               end else begin
                  st_in  = PH_MAGIC0;
                  cnt_in = '0;
                  crc_in = CRC_INIT;
               end
            end
         end
         PH_TYPE: begin
            if (accept) begin
               ftype_in = req_rx_byte;
               crc_in   = crc16_feed(CRC_INIT, req_rx_byte);
               st_in    = PH_LENLO;
            end
         end
         PH_LENLO: begin
            if (accept) begin
               flen_in = {8'h00, req_rx_byte};
               crc_in  = crc16_feed(crc_ff, req_rx_byte);
               st_in   = PH_LENHI;
            end
         end
         PH_LENHI: begin
            if (accept) begin
               flen_in = len_new;
               crc_in  = crc16_feed(crc_ff, req_rx_byte);
               if (len_new == 16'h0000) begin
                  st_in = PH_CRCLO;
               end else if (len_new <= 16'(BUF_DEPTH)) begin
                  cnt_in = '0;
                  st_in  = PH_DATA;
               end else begin
                  // too large: one error beat, back to hunting
                  rsp_valid_in = 1'b1;
                  kind_in      = KIND_TOO_BIG;
                  mtype_in     = ftype_ff;
                  plen_in      = len_new;
                  hasd_in      = 1'b0;
                  dbyte_in     = 8'h00;
                  bidx_in      = '0;
                  last_in      = 1'b1;
                  st_in        = PH_MAGIC0;
                  cnt_in       = '0;
                  crc_in       = CRC_INIT;
               end
            end
         end
         PH_DATA: begin
            if (accept) begin
               mem_we = 1'b1;
               crc_in = crc16_feed(crc_ff, req_rx_byte);
               cnt_in = cnt_plus;
               if ({9'd0, cnt_plus} >= flen_ff) begin
                  st_in = PH_CRCLO;
               end
            end
         end
         PH_CRCLO: begin
            if (accept) begin
               crc_lo_in = req_rx_byte;
               st_in     = PH_CRCHI;
            end
         end
         PH_CRCHI: begin
            if (accept) begin
               cnt_in = '0;
               crc_in = CRC_INIT;
               if (crc_rx != crc_ff) begin
                  rsp_valid_in = 1'b1;
                  kind_in      = KIND_CRC_ERR;
                  mtype_in     = ftype_ff;
                  plen_in      = flen_ff;
                  hasd_in      = 1'b0;
                  dbyte_in     = 8'h00;
                  bidx_in      = '0;
                  last_in      = 1'b1;
                  st_in        = PH_MAGIC0;
               end else if (flen_ff == 16'h0000) begin
                  // empty good frame: single beat without data
                  rsp_valid_in = 1'b1;
                  kind_in      = KIND_GOOD;
                  mtype_in     = ftype_ff;
                  plen_in      = flen_ff;
                  hasd_in      = 1'b0;
                  dbyte_in     = 8'h00;
                  bidx_in      = '0;
                  last_in      = 1'b1;
                  st_in        = PH_MAGIC0;
               end else begin
                  idx_in = '0;
                  st_in  = ST_READ;
               end
            end
         end
         ST_READ: begin
            // memory data shows up in rd_data_ff next cycle
            mem_rd = 1'b1;
            st_in  = ST_SEND;
         end
         ST_SEND: begin
            // rd_data_ff holds until the beat is loaded, no new read meanwhile
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = KIND_GOOD;
               mtype_in     = ftype_ff;
               plen_in      = flen_ff;
               hasd_in      = 1'b1;
               dbyte_in     = rd_data_ff;
               bidx_in      = idx_ff;
               last_in      = replay_last;
               if (replay_last) begin
                  st_in = PH_MAGIC0;
               end else begin
                  idx_in = idx_ff + ADDR_W'(1);
                  st_in  = ST_READ;
               end
            end
         end
         default: begin
            st_in = PH_MAGIC0;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= PH_MAGIC0;
         magic0_ff    <= 8'hAA;
         magic1_ff    <= 8'h55;
         ftype_ff     <= 8'h00;
         flen_ff      <= 16'h0000;
         cnt_ff       <= '0;
         crc_ff       <= CRC_INIT;
         crc_lo_ff    <= 8'h00;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         magic0_ff    <= magic0_in;
         magic1_ff    <= magic1_in;
         ftype_ff     <= ftype_in;
         flen_ff      <= flen_in;
         cnt_ff       <= cnt_in;
         crc_ff       <= crc_in;
         crc_lo_ff    <= crc_lo_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      // payload of the result beat
      kind_ff  <= kind_in;
      mtype_ff <= mtype_in;
      plen_ff  <= plen_in;
      hasd_ff  <= hasd_in;
      dbyte_ff <= dbyte_in;
      bidx_ff  <= bidx_in;
      last_ff  <= last_in;
   end

   // payload memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         pay_mem[cnt_ff[ADDR_W-1:0]] <= req_rx_byte;
      end
      if (mem_rd) begin
         rd_data_ff <= pay_mem[idx_ff];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_frame_type  = mtype_ff;
   assign rsp_payload_len = plen_ff;
   assign rsp_has_data    = hasd_ff;
   assign rsp_data_byte   = dbyte_ff;
   assign rsp_byte_index  = bidx_ff;
   assign rsp_last        = last_ff;

endmodule
